// ----- hw/rtl/tun_pkg.sv -----
// tun_pkg: shared constants for the triangle unit normal block
// no dependencies; used by the top level and its checker
`default_nettype none

package tun_pkg;

  // default vertex coordinate width, signed q8.8
  localparam int COORD_BITS  = 16;
  // default normal component width, signed q1.(n-2)
  localparam int NORMAL_BITS = 16;

endpackage

`default_nettype wire

// ----- hw/rtl/triangle_unit_normal.sv -----
// triangle_unit_normal: unit face normal of a triangle, fully pipelined
// depends on tun_pkg for parameter defaults
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | nine vertex coordinates, signed q8.8
//  out_    | out | out_tvalid/out_tready| three normal components, degenerate flag
//
// one triangle per cycle unless a held output word stalls the pipe; stages:
// one per quotient bit of the recurrence, plus edges, products, cross
// difference, magnitude, partial squares, square, recurrence setup and output
// rst_n is synchronous and clears only the valid bits
// a stall on out_tready freezes every stage at once; in_tready follows it
`default_nettype none

module triangle_unit_normal #(
  parameter int COORD_BITS  = tun_pkg::COORD_BITS,
  parameter int NORMAL_BITS = tun_pkg::NORMAL_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output      logic                                      in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z, then zero fill
  input  wire logic [((9*COORD_BITS+7)/8)*8-1:0]         in_tdata,
  output      logic                                      out_tvalid,
  input  wire logic                                      out_tready,
  // normal_x, normal_y, normal_z, then zero fill
  output      logic [((3*NORMAL_BITS+7)/8)*8-1:0]        out_tdata,
  // degenerate
  output      logic                                      out_tuser
);

  localparam int CB   = COORD_BITS;
  localparam int NB   = NORMAL_BITS;
  localparam int EW   = CB + 1;           // edge width
  localparam int PW   = 2 * EW;           // product width
  localparam int CW   = PW + 1;           // cross component width, signed
  localparam int MW   = PW;               // cross component magnitude width
  localparam int H    = (MW + 1) / 2;     // low half for the split square
  localparam int LW   = MW - H;           // high half
  localparam int SQ   = 2 * MW;           // square width
  localparam int SW   = SQ + 2;           // sum of three squares
  localparam int WW   = SW + 2 * NB + 1;  // recurrence width
  localparam int NSTG = NB + 8;
  localparam int OUTW = ((3*NB+7)/8)*8;

  logic              en;
  logic [NSTG-1:0]   vld_r;

  // whole pipe advances unless the output word is held
  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // input unpack
  logic [CB-1:0] crd [9];
  for (genvar f = 0; f < 9; f++) begin : g_unpack
    assign crd[f] = in_tdata[f*CB +: CB];
  end

  // stage 1: edges from the first vertex
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        e1_r[a] <= {crd[3+a][CB-1], crd[3+a]} - {crd[a][CB-1], crd[a]};
        e2_r[a] <= {crd[6+a][CB-1], crd[6+a]} - {crd[a][CB-1], crd[a]};
      end
    end
  end

  // stage 2..4: cross product, then sign and magnitude
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  logic signed [CW-1:0] cr_r [3];
  logic        [MW-1:0] mag_r [3];
  logic        [2:0]    sg4_r;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    logic [CW-1:0] cr_neg;
    assign cr_neg = -cr_r[i];
    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[i]  <= e1_r[A] * e2_r[B];
        pb_r[i]  <= e1_r[B] * e2_r[A];
        cr_r[i]  <= {pa_r[i][PW-1], pa_r[i]} - {pb_r[i][PW-1], pb_r[i]};
        mag_r[i] <= cr_r[i][CW-1] ? cr_neg[MW-1:0] : cr_r[i][MW-1:0];
        sg4_r[i] <= cr_r[i][CW-1];
      end
    end
  end

  // stage 5..6: square of each magnitude from half-width partial products
  logic [2*LW-1:0] hh_r [3];
  logic [LW+H-1:0] hl_r [3];
  logic [2*H-1:0]  ll_r [3];
  logic [SQ-1:0]   sq_r [3];
  logic [2:0]      sg5_r, sg6_r;

  for (genvar i = 0; i < 3; i++) begin : g_square
    logic [LW-1:0] hi;
    logic [H-1:0]  lo;
    assign hi = mag_r[i][MW-1:H];
    assign lo = mag_r[i][H-1:0];
    always_ff @(posedge clk) begin
      if (en) begin
        hh_r[i] <= hi * hi;
        hl_r[i] <= hi * lo;
        ll_r[i] <= lo * lo;
        sq_r[i] <= (SQ'(hh_r[i]) << (2*H)) + (SQ'(hl_r[i]) << (H+1)) + SQ'(ll_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg5_r <= sg4_r;
      sg6_r <= sg5_r;
    end
  end

  // stage 7 onward: greedy bit recurrence for the largest t with
  // t*t*s <= c*c * 2^(2*(NB-1)); d holds the residue and y holds t*s
  logic [WW-1:0] it_d_r [NB+1][3];
  logic [WW-1:0] it_y_r [NB+1][3];
  logic [NB-1:0] it_t_r [NB+1][3];
  logic [SW-1:0] it_s_r [NB+1];
  logic [2:0]    it_g_r [NB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      it_s_r[0] <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      it_g_r[0] <= sg6_r;
      for (int i = 0; i < 3; i++) begin
        it_d_r[0][i] <= WW'(sq_r[i]) << (2*(NB-1));
        it_y_r[0][i] <= '0;
        it_t_r[0][i] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= NB; j++) begin : g_iter
    localparam int K = NB - j;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [WW-1:0] term;
      logic          ge;
      assign term = (it_y_r[j-1][i] << (K+1)) + (WW'(it_s_r[j-1]) << (2*K));
      assign ge   = it_d_r[j-1][i] >= term;
      always_ff @(posedge clk) begin
        if (en) begin
          it_d_r[j][i] <= ge ? it_d_r[j-1][i] - term : it_d_r[j-1][i];
          it_y_r[j][i] <= ge ? it_y_r[j-1][i] + (WW'(it_s_r[j-1]) << K) : it_y_r[j-1][i];
          it_t_r[j][i] <= it_t_r[j-1][i] | (ge ? NB'(1) << K : NB'(0));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        it_s_r[j] <= it_s_r[j-1];
        it_g_r[j] <= it_g_r[j-1];
      end
    end
  end

  // output stage: round t/2 half up, apply sign, zero on degenerate
  logic [NB-1:0] nrm_r [3];
  logic          deg_r;
  logic          deg;
  assign deg = it_s_r[NB] == '0;

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [NB:0]   tp;
    logic [NB-1:0] m;
    assign tp = {1'b0, it_t_r[NB][i]} + (NB+1)'(1);
    assign m  = tp[NB:1];
    always_ff @(posedge clk) begin
      if (en) begin
        nrm_r[i] <= deg ? '0 : (it_g_r[NB][i] ? -m : m);
      end
    end
    assign out_tdata[i*NB +: NB] = nrm_r[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= deg;
    end
  end

  if (OUTW > 3*NB) begin : g_pad
    assign out_tdata[OUTW-1:3*NB] = '0;
  end

  assign out_tuser = deg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tun_checker.sv -----
// tun_checker: port-level checks for triangle_unit_normal, bound to the top
// depends on tun_pkg for parameter defaults
`default_nettype none

module tun_checker #(
  parameter int COORD_BITS  = tun_pkg::COORD_BITS,
  parameter int NORMAL_BITS = tun_pkg::NORMAL_BITS
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [((9*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [((3*NORMAL_BITS+7)/8)*8-1:0]  out_tdata,
  input wire logic                                out_tuser
);

  localparam int NB = NORMAL_BITS;
  localparam logic signed [NB:0] ONE  = (NB+1)'(1) << (NB-2);
  localparam logic signed [NB:0] MONE = -ONE;

  logic signed [NB:0] nx;
  assign nx = {out_tdata[NB-1], out_tdata[NB-1:0]};

  // held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // input side only stalls when the output word is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // degenerate triangle gives a zero normal
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3*NB-1:0] == '0)
    else $error("degenerate result with nonzero normal");

  // x component never exceeds one in magnitude
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (nx <= ONE) && (nx >= MONE))
    else $error("normal x out of range");

  // an empty pipe cannot show a result without any accepted word
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result right after reset");

endmodule

bind triangle_unit_normal tun_checker #(
  .COORD_BITS  (COORD_BITS),
  .NORMAL_BITS (NORMAL_BITS)
) u_tun_checker (.*);

`default_nettype wire
